// ----- rtl/ltb_pkg.sv -----
package ltb_pkg;

  localparam int MAX_CLUSTERS = 1024;
  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_READ     = 5'd2;
  localparam logic [4:0] OP_READ_OUT = 5'd3;
  localparam logic [4:0] OP_CLEAR    = 5'd4;
  localparam logic [4:0] OP_LC_REQ   = 5'd5;
  localparam logic [4:0] OP_LC_SET   = 5'd6;
  localparam logic [4:0] OP_INIT     = 5'd7;
  localparam logic [4:0] OP_LINK_REQ = 5'd8;
  localparam logic [4:0] OP_LINK_WR  = 5'd9;
  localparam logic [4:0] OP_PAIR_REQ = 5'd10;
  localparam logic [4:0] OP_PAIR_CHK = 5'd11;
  localparam logic [4:0] OP_PAIR_HI  = 5'd12;
  localparam logic [4:0] OP_PAIR_LOW = 5'd13;
  localparam logic [4:0] OP_ROOT_REQ = 5'd14;
  localparam logic [4:0] OP_ROOT_WR  = 5'd15;
  localparam logic [4:0] OP_TOP_REQ  = 5'd16;
  localparam logic [4:0] OP_TOP_LOAD = 5'd17;
  localparam logic [4:0] OP_CAP_REQ  = 5'd18;
  localparam logic [4:0] OP_CAP_WR   = 5'd19;
  localparam logic [4:0] OP_FINISH   = 5'd20;

  localparam logic [2:0] ADDR_POINT_COUNT   = 3'd0;
  localparam logic [2:0] ADDR_MIN_LEAF_SIZE = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [20:0] parent_id;
    logic [20:0] child_id;
    logic [31:0] row_distance;
    logic [31:0] child_weight;
    logic        is_cluster_row;
    logic        last_row;
    logic [9:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [9:0]  entry_index;
    logic [9:0]  parent_entry;
    logic [31:0] birth_distance;
    logic [31:0] death_distance;
    logic [31:0] leaf_size_low;
    logic [31:0] leaf_size_high;
    logic        in_range;
    logic        overflow_seen;
  } out_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic init_last;
    logic link_last;
    logic pair_done;
    logic pair_skip;
    logic root_needed;
    logic cap_done;
    logic cap_last;
    logic clr_last;
  } sts_t;

endpackage

// ----- rtl/ltb_ctrl.sv -----
module ltb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  input  logic          in_last_row,
  input  logic          out_stall,
  input  ltb_pkg::sts_t sts,
  output ltb_pkg::cmd_t cmd,
  output logic          in_stall,
  output logic          out_valid
);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_READ_OUT  = 5'd2;
  localparam logic [4:0] S_LC_REQ    = 5'd3;
  localparam logic [4:0] S_LC_SET    = 5'd4;
  localparam logic [4:0] S_INIT      = 5'd5;
  localparam logic [4:0] S_LINK_REQ  = 5'd6;
  localparam logic [4:0] S_LINK_WR   = 5'd7;
  localparam logic [4:0] S_PAIR_TEST = 5'd8;
  localparam logic [4:0] S_PAIR_REQ  = 5'd9;
  localparam logic [4:0] S_PAIR_CHK  = 5'd10;
  localparam logic [4:0] S_PAIR_HI   = 5'd11;
  localparam logic [4:0] S_PAIR_LOW  = 5'd12;
  localparam logic [4:0] S_ROOT_REQ  = 5'd13;
  localparam logic [4:0] S_ROOT_WR   = 5'd14;
  localparam logic [4:0] S_TOP_REQ   = 5'd15;
  localparam logic [4:0] S_TOP_LOAD  = 5'd16;
  localparam logic [4:0] S_CAP_REQ   = 5'd17;
  localparam logic [4:0] S_CAP_WR    = 5'd18;
  localparam logic [4:0] S_FINISH    = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign accept    = (state_r == S_IDLE) && in_valid && !out_valid_r;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ltb_pkg::OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = ltb_pkg::OP_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req_type) begin
            cmd.op    = ltb_pkg::OP_READ;
            state_nxt = S_READ_OUT;
          end else begin
            cmd.op = ltb_pkg::OP_LOAD;
            if (in_last_row) state_nxt = S_LC_REQ;
          end
        end
      end
      S_READ_OUT: begin
        cmd.op    = ltb_pkg::OP_READ_OUT;
        state_nxt = S_IDLE;
      end
      S_LC_REQ: begin
        cmd.op    = ltb_pkg::OP_LC_REQ;
        state_nxt = S_LC_SET;
      end
      S_LC_SET: begin
        cmd.op    = ltb_pkg::OP_LC_SET;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op = ltb_pkg::OP_INIT;
        if (sts.init_last) state_nxt = sts.n_zero ? S_TOP_REQ : S_LINK_REQ;
      end
      S_LINK_REQ: begin
        cmd.op    = ltb_pkg::OP_LINK_REQ;
        state_nxt = S_LINK_WR;
      end
      S_LINK_WR: begin
        cmd.op    = ltb_pkg::OP_LINK_WR;
        state_nxt = sts.link_last ? S_PAIR_TEST : S_LINK_REQ;
      end
      S_PAIR_TEST: begin
        state_nxt = sts.pair_done ? S_TOP_REQ : S_PAIR_REQ;
      end
      S_PAIR_REQ: begin
        cmd.op    = ltb_pkg::OP_PAIR_REQ;
        state_nxt = S_PAIR_CHK;
      end
      S_PAIR_CHK: begin
        cmd.op    = ltb_pkg::OP_PAIR_CHK;
        state_nxt = sts.pair_skip ? S_PAIR_TEST : S_PAIR_HI;
      end
      S_PAIR_HI: begin
        cmd.op    = ltb_pkg::OP_PAIR_HI;
        state_nxt = S_PAIR_LOW;
      end
      S_PAIR_LOW: begin
        cmd.op    = ltb_pkg::OP_PAIR_LOW;
        state_nxt = sts.root_needed ? S_ROOT_REQ : S_PAIR_TEST;
      end
      S_ROOT_REQ: begin
        cmd.op    = ltb_pkg::OP_ROOT_REQ;
        state_nxt = S_ROOT_WR;
      end
      S_ROOT_WR: begin
        cmd.op    = ltb_pkg::OP_ROOT_WR;
        state_nxt = S_PAIR_TEST;
      end
      S_TOP_REQ: begin
        cmd.op    = ltb_pkg::OP_TOP_REQ;
        state_nxt = S_TOP_LOAD;
      end
      S_TOP_LOAD: begin
        cmd.op    = ltb_pkg::OP_TOP_LOAD;
        state_nxt = sts.cap_done ? S_FINISH : S_CAP_REQ;
      end
      S_CAP_REQ: begin
        cmd.op    = ltb_pkg::OP_CAP_REQ;
        state_nxt = S_CAP_WR;
      end
      S_CAP_WR: begin
        cmd.op    = ltb_pkg::OP_CAP_WR;
        state_nxt = sts.cap_last ? S_FINISH : S_CAP_REQ;
      end
      S_FINISH: begin
        cmd.op    = ltb_pkg::OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (state_r == S_READ_OUT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/ltb_dp.sv -----
module ltb_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  ltb_pkg::cmd_t cmd,
  input  ltb_pkg::in_t  in_data,
  input  logic [19:0]   point_count,
  input  logic [31:0]   min_leaf_size,
  output ltb_pkg::sts_t sts,
  output ltb_pkg::out_t out_data
);

  localparam int IW  = ltb_pkg::IDX_W;
  localparam int CW  = ltb_pkg::CNT_W;
  localparam int MAX = ltb_pkg::MAX_CLUSTERS;

  logic [2*IW-1:0] link_mem  [MAX];
  logic [31:0]     dist_mem  [MAX];
  logic [31:0]     wgt_mem   [MAX];
  logic [IW-1:0]   lpar_mem  [MAX];
  logic [31:0]     birth_mem [MAX];
  logic [31:0]     death_mem [MAX];
  logic [31:0]     low_mem   [MAX];
  logic [31:0]     high_mem  [MAX];

  logic [2*IW-1:0] link_rd_r;
  logic [31:0]     dist_rd_r, wa_rd_r, wb_rd_r, birth_rd_r, death_rd_r;
  logic [31:0]     lowa_rd_r, lowb_rd_r, high_rd_r;
  logic [IW-1:0]   lpar_rd_r;

  logic [IW-1:0] link_ra, lpar_ra, lowa_ra, lowb_ra, rd_ra;
  logic          lpar_we, death_we, low_we, high_we;
  logic [IW-1:0] lpar_wa, death_wa, low_wa, high_wa;
  logic [IW-1:0] lpar_wd;
  logic [31:0]   death_wd, low_wd, high_wd;

  logic [CW-1:0] row_cnt_r, lc_r, k_r, left_r;
  logic          first_seen_r, ovf_r;
  logic [31:0]   first_dist_r;
  logic [9:0]    idx_r;
  logic          ok_r;
  logic [31:0]   size_r, low_val_r, root_low_r;
  logic [IW-1:0] out_r, par_r;
  logic          root_needed_r;
  ltb_pkg::out_t out_data_r;

  logic [21:0]   p_diff, c_diff;
  logic          p_ok, c_ok, keep, room;
  logic [IW-1:0] p_ent, c_ent, q_par, q_child;
  logic [31:0]   size_c, low_max, root_max;

  assign p_diff = {1'b0, in_data.parent_id} - {2'b00, point_count};
  assign c_diff = {1'b0, in_data.child_id} - {2'b00, point_count};
  assign p_ok   = !p_diff[21] && (p_diff[20:0] < 21'(MAX));
  assign c_ok   = !c_diff[21] && (c_diff[20:0] < 21'(MAX));
  assign p_ent  = IW'(p_diff[20:0]);
  assign c_ent  = IW'(c_diff[20:0]);
  assign room   = row_cnt_r < CW'(MAX);
  assign keep   = (cmd.op == ltb_pkg::OP_LOAD) && in_data.is_cluster_row && p_ok && c_ok
                  && room;

  assign q_par   = link_rd_r[2*IW-1:IW];
  assign q_child = link_rd_r[IW-1:0];
  assign size_c  = (wa_rd_r < wb_rd_r) ? wa_rd_r : wb_rd_r;

  always_comb begin
    low_max = size_r;
    if (lowa_rd_r > low_max) low_max = lowa_rd_r;
    if (lowb_rd_r > low_max) low_max = lowb_rd_r;
  end

  assign root_max = (lowa_rd_r > low_val_r) ? lowa_rd_r : low_val_r;
  assign rd_ra    = IW'(in_data.read_index);

  always_comb begin
    link_ra = IW'(k_r);
    lpar_ra = rd_ra;
    lowa_ra = rd_ra;
    lowb_ra = q_child;
    unique case (cmd.op)
      ltb_pkg::OP_LC_REQ:   link_ra = IW'(row_cnt_r - 1'b1);
      ltb_pkg::OP_PAIR_REQ: link_ra = IW'(left_r);
      default:              link_ra = IW'(k_r);
    endcase
    unique case (cmd.op)
      ltb_pkg::OP_PAIR_CHK: lpar_ra = q_par;
      ltb_pkg::OP_CAP_REQ:  lpar_ra = IW'(k_r);
      default:              lpar_ra = rd_ra;
    endcase
    unique case (cmd.op)
      ltb_pkg::OP_READ:     lowa_ra = rd_ra;
      ltb_pkg::OP_PAIR_CHK: lowa_ra = q_child - 1'b1;
      default:              lowa_ra = '0;
    endcase
  end

  always_comb begin
    lpar_we  = 1'b0;
    lpar_wa  = IW'(k_r);
    lpar_wd  = '0;
    death_we = 1'b0;
    death_wa = IW'(k_r);
    death_wd = first_dist_r;
    low_we   = 1'b0;
    low_wa   = IW'(k_r);
    low_wd   = min_leaf_size;
    high_we  = 1'b0;
    high_wa  = IW'(k_r);
    high_wd  = '0;
    unique case (cmd.op)
      ltb_pkg::OP_CLEAR: begin
        high_we = 1'b1;
      end
      ltb_pkg::OP_INIT: begin
        lpar_we  = 1'b1;
        death_we = 1'b1;
        low_we   = 1'b1;
      end
      ltb_pkg::OP_LINK_WR: begin
        lpar_we  = CW'(q_child) < lc_r;
        lpar_wa  = q_child;
        lpar_wd  = q_par;
        death_we = CW'(q_child) < lc_r;
        death_wa = q_child;
        death_wd = dist_rd_r;
      end
      ltb_pkg::OP_PAIR_CHK: begin
        high_we = !sts.pair_skip;
        high_wa = q_child;
        high_wd = size_c;
      end
      ltb_pkg::OP_PAIR_HI: begin
        high_we = 1'b1;
        high_wa = out_r - 1'b1;
        high_wd = size_r;
      end
      ltb_pkg::OP_PAIR_LOW: begin
        low_we = 1'b1;
        low_wa = par_r;
        low_wd = low_val_r;
      end
      ltb_pkg::OP_ROOT_WR: begin
        low_we = 1'b1;
        low_wa = '0;
        low_wd = root_max;
      end
      ltb_pkg::OP_TOP_REQ: begin
        high_we = 1'b1;
        high_wa = '0;
        high_wd = 32'(point_count) << 8;
      end
      ltb_pkg::OP_CAP_WR: begin
        high_we = (lpar_rd_r == '0);
        high_wd = root_low_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      link_mem[IW'(row_cnt_r)] <= {p_ent, c_ent};
      dist_mem[IW'(row_cnt_r)] <= in_data.row_distance;
      wgt_mem[IW'(row_cnt_r)]  <= in_data.child_weight;
    end
    link_rd_r <= link_mem[link_ra];
    dist_rd_r <= dist_mem[IW'(k_r)];
    wa_rd_r   <= wgt_mem[IW'(left_r)];
    wb_rd_r   <= wgt_mem[IW'(left_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == ltb_pkg::OP_LOAD) && p_ok) birth_mem[p_ent] <= in_data.row_distance;
    birth_rd_r <= birth_mem[rd_ra];
  end

  always_ff @(posedge clk) begin
    if (lpar_we) lpar_mem[lpar_wa] <= lpar_wd;
    lpar_rd_r <= lpar_mem[lpar_ra];
  end

  always_ff @(posedge clk) begin
    if (death_we) death_mem[death_wa] <= death_wd;
    death_rd_r <= death_mem[rd_ra];
  end

  always_ff @(posedge clk) begin
    if (low_we) low_mem[low_wa] <= low_wd;
    lowa_rd_r <= low_mem[lowa_ra];
    lowb_rd_r <= low_mem[lowb_ra];
  end

  always_ff @(posedge clk) begin
    if (high_we) high_mem[high_wa] <= high_wd;
    high_rd_r <= high_mem[rd_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r    <= '0;
      first_seen_r <= 1'b0;
      first_dist_r <= '0;
      lc_r         <= CW'(1);
      ovf_r        <= 1'b0;
      k_r          <= '0;
      left_r       <= '0;
    end else begin
      unique case (cmd.op)
        ltb_pkg::OP_LOAD: begin
          if (!first_seen_r) begin
            first_dist_r <= in_data.row_distance;
            first_seen_r <= 1'b1;
          end
          if (!p_ok || (in_data.is_cluster_row && (!c_ok || (p_ok && !room)))) begin
            ovf_r <= 1'b1;
          end
          if (keep) row_cnt_r <= row_cnt_r + 1'b1;
        end
        ltb_pkg::OP_CLEAR: begin
          k_r <= sts.clr_last ? '0 : k_r + 1'b1;
        end
        ltb_pkg::OP_LC_SET: begin
          lc_r <= sts.n_zero ? CW'(1) : CW'(q_child) + 1'b1;
          k_r  <= '0;
        end
        ltb_pkg::OP_INIT: begin
          k_r <= sts.init_last ? '0 : k_r + 1'b1;
        end
        ltb_pkg::OP_LINK_WR: begin
          k_r    <= k_r + 1'b1;
          left_r <= row_cnt_r - 1'b1;
        end
        ltb_pkg::OP_PAIR_CHK: begin
          if (sts.pair_skip) left_r <= left_r - CW'(2);
        end
        ltb_pkg::OP_PAIR_LOW: begin
          left_r <= left_r - CW'(2);
        end
        ltb_pkg::OP_TOP_REQ: begin
          k_r <= CW'(1);
        end
        ltb_pkg::OP_CAP_WR: begin
          k_r <= k_r + 1'b1;
        end
        ltb_pkg::OP_FINISH: begin
          row_cnt_r    <= '0;
          first_seen_r <= 1'b0;
          first_dist_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ltb_pkg::OP_READ) begin
      idx_r <= in_data.read_index;
      ok_r  <= 32'(in_data.read_index) < 32'(lc_r);
    end
    if (cmd.op == ltb_pkg::OP_PAIR_CHK) begin
      size_r <= size_c;
      out_r  <= q_child;
      par_r  <= q_par;
    end
    if (cmd.op == ltb_pkg::OP_PAIR_HI) begin
      low_val_r     <= low_max;
      root_needed_r <= (lpar_rd_r == '0);
    end
    if (cmd.op == ltb_pkg::OP_TOP_LOAD) root_low_r <= lowa_rd_r;
    if (cmd.op == ltb_pkg::OP_READ_OUT) begin
      out_data_r.entry_index    <= idx_r;
      out_data_r.parent_entry   <= ok_r ? 10'(lpar_rd_r) : '0;
      out_data_r.birth_distance <= ok_r ? birth_rd_r : '0;
      out_data_r.death_distance <= ok_r ? death_rd_r : '0;
      out_data_r.leaf_size_low  <= ok_r ? lowa_rd_r : '0;
      out_data_r.leaf_size_high <= ok_r ? high_rd_r : '0;
      out_data_r.in_range       <= ok_r;
      out_data_r.overflow_seen  <= ovf_r;
    end
  end

  assign out_data = out_data_r;

  assign sts.n_zero      = (row_cnt_r == '0);
  assign sts.init_last   = (k_r == lc_r - 1'b1);
  assign sts.link_last   = (k_r == row_cnt_r - 1'b1);
  assign sts.pair_done   = (left_r == '0) || left_r[CW-1];
  assign sts.pair_skip   = (q_child == '0) || (CW'(q_child) >= lc_r) || (CW'(q_par) >= lc_r);
  assign sts.root_needed = root_needed_r;
  assign sts.cap_done    = (k_r >= lc_r);
  assign sts.cap_last    = (k_r == lc_r - 1'b1);
  assign sts.clr_last    = (k_r == CW'(MAX - 1));

endmodule

// ----- rtl/leaf_tree_builder_core.sv -----
// Load: one input row. Read: stores read at accept, result registered in S_READ_OUT, then valid.
// A load with last_row starts a build: init of L leaves, link of N kept cluster rows, then
// pairing of P = N/2 sibling pairs and top and cap passes; with no cluster row, init to top.
// One transaction at a time; input stalls during a build and while a result waits.
// Reset: control cleared, then a pass over all 1024 entries zeroes the leaf size ceiling store;
// config writes are taken during that pass.
module leaf_tree_builder_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ltb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ltb_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [19:0]   point_count_r;
  logic [31:0]   min_leaf_size_r;
  logic          cfg_wr;
  ltb_pkg::cmd_t cmd;
  ltb_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? min_leaf_size_r : {12'd0, point_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r   <= 20'd1;
      min_leaf_size_r <= 32'd1280;
    end else if (cfg_wr) begin
      if (paddr[2] == ltb_pkg::ADDR_MIN_LEAF_SIZE[2]) min_leaf_size_r <= pwdata;
      else if (paddr[2] == ltb_pkg::ADDR_POINT_COUNT[2]) point_count_r <= pwdata[19:0];
    end
  end

  ltb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_last_row (in_data.last_row),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd),
    .in_stall    (in_stall),
    .out_valid   (out_valid)
  );

  ltb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_data       (in_data),
    .point_count   (point_count_r),
    .min_leaf_size (min_leaf_size_r),
    .sts           (sts),
    .out_data      (out_data)
  );

  a_no_accept_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while a result waits");

  a_build_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.req_type && in_data.last_row) |=> in_stall)
    else $error("build did not stall input");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.req_type) |=> ##1 out_valid)
    else $error("read result missing");

endmodule

// ----- tb/leaf_tree_builder_core_tb.sv -----
module leaf_tree_builder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCL = ltb_pkg::MAX_CLUSTERS;
  localparam int SETTLE_CYCLES = 20000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ltb_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ltb_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  leaf_tree_builder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [19:0] pc_r;
  logic [31:0] mls_r;
  logic [9:0]  row_par [NCL];
  logic [9:0]  row_child [NCL];
  logic [31:0] row_dist [NCL];
  logic [31:0] row_wt [NCL];
  logic [9:0]  lf_par [NCL];
  logic [31:0] lf_birth [NCL];
  logic [31:0] lf_death [NCL];
  logic [31:0] lf_low [NCL];
  logic [31:0] lf_high [NCL];
  bit          birth_def [NCL];
  bit          body_def [NCL];
  int          row_cnt;
  logic [31:0] first_dist;
  bit          first_seen;
  int          leaves;
  bit          ovf;

  ltb_pkg::in_t  send_q [$];
  ltb_pkg::out_t leaf_entry_q [$];
  int   n_items = 0;
  int   errors = 0;
  bit   quiet = 0;
  int   long_hold = 0;
  int   gap = 0;
  int   stall_cnt = 0;

  function automatic bit id_entry(logic [20:0] id, output int e);
    int d;
    d = int'(id) - int'(pc_r);
    e = 0;
    if (d < 0 || d >= NCL) return 0;
    e = d;
    return 1;
  endfunction

  function automatic logic [31:0] umax(logic [31:0] a, logic [31:0] b);
    return a > b ? a : b;
  endfunction

  function automatic void build_leaves();
    int n, lft, rgt, o, p;
    logic [31:0] sz, lo;
    n = row_cnt;
    leaves = n == 0 ? 1 : int'(row_child[n-1]) + 1;
    for (int k = 0; k < leaves; k++) begin
      lf_par[k] = '0;
      lf_death[k] = first_dist;
      lf_low[k] = mls_r;
      body_def[k] = 1;
    end
    for (int k = 0; k < n; k++) begin
      if (int'(row_child[k]) < leaves) begin
        lf_par[row_child[k]] = row_par[k];
        lf_death[row_child[k]] = row_dist[k];
      end
    end
    for (int i = 1; i <= n; i += 2) begin
      lft = n - i;
      if (lft == 0) continue;
      rgt = lft - 1;
      sz = row_wt[lft] < row_wt[rgt] ? row_wt[lft] : row_wt[rgt];
      o = int'(row_child[lft]);
      p = int'(row_par[lft]);
      if (o == 0 || o >= leaves || p >= leaves) continue;
      lf_high[o] = sz;
      lf_high[o-1] = sz;
      lo = umax(sz, umax(lf_low[o-1], lf_low[o]));
      lf_low[p] = lo;
      if (lf_par[p] == 0) lf_low[0] = umax(lf_low[0], lo);
    end
    lf_high[0] = {4'h0, pc_r, 8'h00};
    for (int k = 1; k < leaves; k++)
      if (lf_par[k] == 0) lf_high[k] = lf_low[0];
    row_cnt = 0;
    first_seen = 0;
    first_dist = '0;
  endfunction

  function automatic bit predict_leaf(ltb_pkg::in_t it, output ltb_pkg::out_t o);
    int p, c;
    bit p_ok, c_ok, ok;
    o = '0;
    if (it.req_type) begin
      ok = int'(it.read_index) < leaves;
      o.entry_index = it.read_index;
      if (ok) begin
        o.parent_entry = lf_par[it.read_index];
        o.birth_distance = lf_birth[it.read_index];
        o.death_distance = lf_death[it.read_index];
        o.leaf_size_low = lf_low[it.read_index];
        o.leaf_size_high = lf_high[it.read_index];
      end
      o.in_range = ok;
      o.overflow_seen = ovf;
      return 1;
    end
    if (!first_seen) begin
      first_dist = it.row_distance;
      first_seen = 1;
    end
    p_ok = id_entry(it.parent_id, p);
    if (p_ok) begin
      lf_birth[p] = it.row_distance;
      birth_def[p] = 1;
    end else ovf = 1;
    if (it.is_cluster_row) begin
      c_ok = id_entry(it.child_id, c);
      if (!c_ok) ovf = 1;
      if (p_ok && c_ok) begin
        if (row_cnt < NCL) begin
          row_par[row_cnt] = 10'(p);
          row_child[row_cnt] = 10'(c);
          row_dist[row_cnt] = it.row_distance;
          row_wt[row_cnt] = it.child_weight;
          row_cnt++;
        end else ovf = 1;
      end
    end
    if (it.last_row) build_leaves();
    return 0;
  endfunction

  function automatic bit can_read(int idx);
    return idx >= leaves || (birth_def[idx] && body_def[idx]);
  endfunction

  function automatic ltb_pkg::in_t load_row(logic [20:0] p, logic [20:0] c, logic [31:0] d,
                                            logic [31:0] w, bit isc, bit last);
    ltb_pkg::in_t it;
    it = '0;
    it.req_type = 1'b0;
    it.parent_id = p;
    it.child_id = c;
    it.row_distance = d;
    it.child_weight = w;
    it.is_cluster_row = isc;
    it.last_row = last;
    it.read_index = 10'($urandom);
    return it;
  endfunction

  function automatic ltb_pkg::in_t read_row(int idx);
    ltb_pkg::in_t it;
    it = '0;
    it.req_type = 1'b1;
    it.parent_id = 21'($urandom);
    it.child_id = 21'($urandom);
    it.row_distance = $urandom;
    it.child_weight = $urandom;
    it.is_cluster_row = 1'($urandom);
    it.last_row = 1'($urandom);
    it.read_index = 10'(idx);
    return it;
  endfunction

  task automatic push_item(ltb_pkg::in_t it);
    ltb_pkg::out_t o;
    if (predict_leaf(it, o)) leaf_entry_q.push_back(o);
    send_q.push_back(it);
    n_items++;
  endtask

  task automatic try_read(int idx);
    if (can_read(idx)) push_item(read_row(idx));
  endtask

  function automatic logic [31:0] rand_wt();
    return $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom;
  endfunction

  task automatic gen_tree(int nl, bit noise, bit sparse);
    logic [20:0] base;
    int p;
    base = 21'(pc_r);
    if (noise && $urandom_range(0, 2) == 0)
      push_item(load_row(base + 21'($urandom_range(0, nl - 1)),
                         base + 21'($urandom_range(1, nl)), $urandom, rand_wt(), 1, 0));
    if ($urandom_range(0, 9) != 0)
      push_item(load_row(base, 21'($urandom_range(0, 2000)), $urandom, rand_wt(), 0, 0));
    for (int c = 1; c < nl; c += 2) begin
      p = $urandom_range(0, c - 1);
      push_item(load_row(base + 21'(p), base + 21'(c), $urandom, rand_wt(), 1, 0));
      push_item(load_row(base + 21'(p), base + 21'(c + 1), $urandom, rand_wt(), 1, 0));
      for (int s = 0; s < 2; s++)
        if ($urandom_range(0, 9) < (sparse ? 1 : 9))
          push_item(load_row(base + 21'(c + s), 21'($urandom), $urandom, rand_wt(), 0, 0));
      if (noise && $urandom_range(0, 7) == 0)
        push_item(load_row(21'($urandom), 21'($urandom), $urandom, $urandom,
                           1'($urandom), 0));
      if (!sparse && $urandom_range(0, 19) == 0) try_read($urandom_range(0, 1023));
    end
    push_item(load_row(base + 21'($urandom_range(0, nl - 1)), 21'($urandom), $urandom,
                       rand_wt(), 0, 1));
    for (int r = $urandom_range(1, nl + 3); r > 0; r--)
      try_read($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                         : $urandom_range(0, nl + 2));
  endtask

  task automatic random_trees(int target);
    while (n_items < target)
      gen_tree(2 * ($urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6)) + 1,
               $urandom_range(0, 2) == 0, 0);
  endtask

  task automatic drain_and_settle();
    while (send_q.size() > 0 || leaf_entry_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ltb_pkg::ADDR_POINT_COUNT) pc_r = val[19:0];
    else if (addr == ltb_pkg::ADDR_MIN_LEAF_SIZE) mls_r = val;
  endtask

  task automatic set_regs(logic [19:0] pc, logic [31:0] mls);
    drain_and_settle();
    reg_write(ltb_pkg::ADDR_POINT_COUNT, {12'h0, pc});
    reg_write(ltb_pkg::ADDR_MIN_LEAF_SIZE, mls);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic cmp_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_entry(ltb_pkg::out_t g);
    ltb_pkg::out_t e;
    if (leaf_entry_q.size() == 0) begin
      report_mismatch("unexpected transaction", 32'(g.entry_index), '0);
      return;
    end
    e = leaf_entry_q.pop_front();
    cmp_field("entry_index", 32'(g.entry_index), 32'(e.entry_index));
    cmp_field("parent_entry", 32'(g.parent_entry), 32'(e.parent_entry));
    cmp_field("birth_distance", g.birth_distance, e.birth_distance);
    cmp_field("death_distance", g.death_distance, e.death_distance);
    cmp_field("leaf_size_low", g.leaf_size_low, e.leaf_size_low);
    cmp_field("leaf_size_high", g.leaf_size_high, e.leaf_size_high);
    cmp_field("in_range", 32'(g.in_range), 32'(e.in_range));
    cmp_field("overflow_seen", 32'(g.overflow_seen), 32'(e.overflow_seen));
  endtask

  // sender
  initial begin : sender
    bit fire;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      fire = in_valid && !in_stall;
      @(negedge clk);
      if (fire) begin
        void'(send_q.pop_front());
        in_valid = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
      end
      if (!in_valid && send_q.size() > 0) begin
        if (gap > 0) gap--;
        else begin
          in_data = send_q[0];
          in_valid = 1'b1;
        end
      end
    end
  end

  // long receiver hold-off, counted down once per cycle
  initial begin : holder
    forever begin
      @(posedge clk);
      if (long_hold > 0) long_hold--;
    end
  end

  // receiver
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_entry(out_data);
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
        if (!quiet && $urandom_range(0, 6) == 0) stall_cnt = $urandom_range(1, 8);
      end
    end
  end

  initial begin : watchdog
    #20ms;
    $display("leaf_tree_builder_core_tb NOT OK");
    $finish;
  end

  typedef struct {
    ltb_pkg::in_t  it;
    bit            typed;
    ltb_pkg::out_t want;
  } dir_row_t;

  initial begin : main
    dir_row_t dir_rows [$];
    dir_row_t r;
    ltb_pkg::out_t o;
    pc_r = 20'd1;
    mls_r = 32'd1280;
    row_cnt = 0;
    first_dist = '0;
    first_seen = 0;
    leaves = 1;
    ovf = 0;
    for (int k = 0; k < NCL; k++) begin
      lf_high[k] = '0;
      birth_def[k] = 0;
      body_def[k] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reads after reset, small tree, root-only build, overflow
    r.typed = 1;
    r.want = '0;
    r.it = read_row(1);
    r.want.entry_index = 10'd1;
    dir_rows.push_back(r);
    r.it = read_row(1023);
    r.want.entry_index = 10'd1023;
    dir_rows.push_back(r);
    r.typed = 0;
    r.it = load_row(21'd1, 21'd0, 32'h0, 32'h0, 0, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'd1, 21'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'd1, 21'd3, 32'h0001_0000, 32'h0000_0100, 1, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'd2, 21'd7, 32'h0002_0000, 32'h0, 0, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'd3, 21'h1F_FFFF, 32'h0000_8000, 32'h0, 0, 1);
    dir_rows.push_back(r);
    for (int i = 0; i < 3; i++) begin
      r.it = read_row(i);
      dir_rows.push_back(r);
    end
    r.typed = 1;
    r.want = '0;
    r.it = read_row(3);
    r.want.entry_index = 10'd3;
    dir_rows.push_back(r);
    r.typed = 0;
    r.it = load_row(21'd0, 21'd4, 32'h1234_5678, 32'h0, 0, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'h1F_FFFF, 21'd0, 32'h0, 32'h0, 1, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'd1, 21'd1, 32'h0, 32'h0, 1, 0);
    dir_rows.push_back(r);
    r.it = load_row(21'd1, 21'd9, 32'hCAFE_0000, 32'h0, 0, 1);
    dir_rows.push_back(r);
    r.it = read_row(0);
    dir_rows.push_back(r);
    r.typed = 1;
    r.want = '0;
    r.it = read_row(1);
    r.want.entry_index = 10'd1;
    r.want.overflow_seen = 1'b1;
    dir_rows.push_back(r);
    r.it = read_row(1023);
    r.want.entry_index = 10'd1023;
    dir_rows.push_back(r);

    foreach (dir_rows[i]) begin
      if (predict_leaf(dir_rows[i].it, o))
        leaf_entry_q.push_back(dir_rows[i].typed ? dir_rows[i].want : o);
      send_q.push_back(dir_rows[i].it);
      n_items++;
    end

    random_trees(250);

    set_regs(20'd1000, 32'h0);
    gen_tree(3, 0, 0);
    long_hold = 500;
    for (int i = 0; i < 12; i++) try_read($urandom_range(0, 6));
    random_trees(450);

    set_regs(20'hF_FFFF, 32'hFFFF_FFFF);
    gen_tree(1023, 0, 1);
    for (int i = 0; i < 3; i++)
      push_item(load_row(21'(pc_r), 21'(pc_r) + 21'd1, $urandom, $urandom, 1, 0));
    push_item(load_row(21'(pc_r), 21'd0, $urandom, $urandom, 0, 1));
    for (int i = 0; i < 8; i++) try_read($urandom_range(0, 1023));
    random_trees(1700);

    set_regs(20'd1, 32'd7);
    random_trees(1800);

    set_regs(20'd37, $urandom);
    quiet = 1;
    random_trees(1900);

    drain_and_settle();
    if (errors == 0) begin
      $display("leaf_tree_builder_core_tb OK");
    end else begin
      $display("leaf_tree_builder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
